// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the distance core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: hw/rtl/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg
// Widths, metric codes, step counts and the request/response types of the
// shared divide and square-root unit.
// ----------------------------------------------------------------------------
package pvd_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
  localparam int VAL_W       = 32;
  localparam int DIFF_W      = 32;
  localparam int SUM_W       = 33;
  localparam int ACC_W       = 64;
  localparam int PROD_W      = 64;
  localparam int MUL_W       = 32;
  localparam int DIST_W      = 48;
  localparam int FRAC_W      = 16;
  localparam int PART_W      = MUL_W + CNT_W;
  localparam int SCALE_W     = ACC_W + CNT_W;
  localparam int WORK_W      = ACC_W + FRAC_W;
  localparam int ROOT_W      = WORK_W / 2;
  localparam int REM_W       = ROOT_W + 3;
  localparam int STEP_W      = $clog2(WORK_W + 1);

  localparam logic [2:0] METRIC_EUCLID  = 3'd0;
  localparam logic [2:0] METRIC_MAXIMUM = 3'd1;
  localparam logic [2:0] METRIC_MANHATT = 3'd2;
  localparam logic [2:0] METRIC_CANBERRA = 3'd3;
  localparam logic [2:0] METRIC_BINARY  = 3'd4;

  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_ROOT = 1'b1;

  localparam logic [STEP_W-1:0] CANB_STEPS  = STEP_W'(DIFF_W + FRAC_W);
  localparam logic [STEP_W-1:0] BIN_STEPS   = STEP_W'(CNT_W + FRAC_W);
  localparam logic [STEP_W-1:0] SCALE_STEPS = STEP_W'(SCALE_W);
  localparam logic [STEP_W-1:0] ROOT_STEPS  = STEP_W'(ROOT_W);

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic              start;
    logic              op;
    logic [STEP_W-1:0] steps;
    logic [WORK_W-1:0] operand;
    logic [SUM_W-1:0]  divisor;
  } pvd_req_t;

  typedef struct packed {
    logic             done;
    logic             overflow;
    logic [ACC_W-1:0] value;
  } pvd_resp_t;

endpackage

// File: hw/rtl/pvd_divsqrt.sv
// ----------------------------------------------------------------------------
// pvd_divsqrt
// Shared restoring divider and square-root unit: one compare-subtract per
// cycle, one quotient or root bit per step, operand left-aligned by caller.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvd_divsqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  pvd_pkg::pvd_req_t    req,
  output pvd_pkg::pvd_resp_t   resp
);

  logic                         busy;
  logic                         done;
  logic                         op;
  logic [pvd_pkg::STEP_W-1:0]   count;
  logic [pvd_pkg::REM_W-1:0]    rem;
  logic [pvd_pkg::WORK_W-1:0]   work;
  logic [pvd_pkg::ROOT_W-1:0]   root;
  logic [pvd_pkg::SUM_W-1:0]    divisor;
  logic [pvd_pkg::REM_W-1:0]    minuend;
  logic [pvd_pkg::REM_W-1:0]    subtrahend;
  logic [pvd_pkg::REM_W:0]      diff;
  logic                         fits;
  logic                         last_step;
  logic                         launch;

  assign launch    = req.start && !busy;
  assign last_step = busy && (count == pvd_pkg::STEP_W'(1));

  always_comb begin
    if (op == pvd_pkg::OP_ROOT) begin
      minuend    = {rem[pvd_pkg::REM_W-3:0], work[pvd_pkg::WORK_W-1 -: 2]};
      subtrahend = pvd_pkg::REM_W'({root, 2'b01});
    end else begin
      minuend    = {rem[pvd_pkg::REM_W-2:0], work[pvd_pkg::WORK_W-1]};
      subtrahend = pvd_pkg::REM_W'(divisor);
    end
    diff = {1'b0, minuend} - {1'b0, subtrahend};
    fits = !diff[pvd_pkg::REM_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= last_step;
      if (launch) begin
        busy  <= 1'b1;
        count <= req.steps;
      end else if (busy) begin
        count <= count - pvd_pkg::STEP_W'(1);
        if (last_step) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      op      <= req.op;
      work    <= req.operand;
      rem     <= '0;
      root    <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[pvd_pkg::REM_W-1:0] : minuend;
      if (op == pvd_pkg::OP_ROOT) begin
        work <= {work[pvd_pkg::WORK_W-3:0], 2'b00};
        root <= {root[pvd_pkg::ROOT_W-2:0], fits};
      end else begin
        work <= {work[pvd_pkg::WORK_W-2:0], fits};
      end
    end
  end

  assign resp.done     = done;
  assign resp.overflow = (op == pvd_pkg::OP_DIV) &&
                         (|work[pvd_pkg::WORK_W-1:pvd_pkg::ACC_W]);
  assign resp.value    = (op == pvd_pkg::OP_ROOT) ? pvd_pkg::ACC_W'(root)
                                                  : work[pvd_pkg::ACC_W-1:0];

  `ASSERT_IMPLY(a_start_when_free, clk, rst, req.start, !busy)
  `ASSERT_NEXT(a_done_after_last, clk, rst, last_step, done && !busy)

endmodule

// File: hw/rtl/pairwise_vector_distance_core.sv
// ----------------------------------------------------------------------------
// pairwise_vector_distance_core
// Accumulates one distance between two vectors of signed Q16.16 coordinate
// pairs and emits an unsigned Q32.16 result on the last pair.
// ----------------------------------------------------------------------------
// Pairs arrive one transfer at a time; the metric register (0 Euclidean,
// 1 maximum, 2 Manhattan, 3 Canberra, 4 binary) must be written while the
// core is idle. The core takes one pair at a time and holds item_stall high
// while it works: a pair passes ST_IDLE and ST_TERM (Euclidean adds ST_SQ,
// Canberra waits in ST_CAN_WAIT while the shared restoring divide/root unit
// makes one quotient bit per cycle for the 48-bit term division). The last
// pair adds the finishing work on that same unit: the sum rescaling (two
// 32x11 multiplies and a 75-step divide), then the Euclidean square root, or
// the binary ratio. A finished result waits in an output register, so a new
// vector can start while it is not yet taken.

`include "assert_macros.svh"

module pairwise_vector_distance_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [2:0]                  cfg_wr_data,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic signed [pvd_pkg::VAL_W-1:0] value_a,
  input  logic signed [pvd_pkg::VAL_W-1:0] value_b,
  input  logic                        missing_a,
  input  logic                        missing_b,
  input  logic                        last_element,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [pvd_pkg::DIST_W-1:0]  distance,
  output logic                        result_missing,
  output logic                        saturated
);

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_TERM       = 4'd1;
  localparam logic [3:0] ST_SQ         = 4'd2;
  localparam logic [3:0] ST_CAN_WAIT   = 4'd3;
  localparam logic [3:0] ST_FINAL      = 4'd4;
  localparam logic [3:0] ST_SCALE_LO   = 4'd5;
  localparam logic [3:0] ST_SCALE_HI   = 4'd6;
  localparam logic [3:0] ST_SCALE_SUM  = 4'd7;
  localparam logic [3:0] ST_SCALE_WAIT = 4'd8;
  localparam logic [3:0] ST_ROOT_WAIT  = 4'd9;
  localparam logic [3:0] ST_BIN_WAIT   = 4'd10;
  localparam logic [3:0] ST_EMIT       = 4'd11;

  logic [3:0]                    state;
  logic [2:0]                    metric;
  logic [pvd_pkg::ACC_W-1:0]     accumulator;
  logic [pvd_pkg::CNT_W-1:0]     element_count;
  logic [pvd_pkg::CNT_W-1:0]     used_count;
  logic [pvd_pkg::CNT_W-1:0]     union_count;
  logic [pvd_pkg::CNT_W-1:0]     mismatch_count;
  logic [pvd_pkg::DIFF_W-1:0]    largest_difference;
  logic                          any_usable;

  logic [pvd_pkg::DIFF_W-1:0]    d_q;
  logic [pvd_pkg::SUM_W-1:0]     s_q;
  logic                          a_nz;
  logic                          b_nz;
  logic                          miss_q;
  logic                          last_q;
  logic [pvd_pkg::PROD_W-1:0]    prod;
  logic [pvd_pkg::PART_W-1:0]    scaled;
  logic [pvd_pkg::ACC_W-1:0]     val;
  logic                          na_q;
  logic                          ov_q;

  logic [pvd_pkg::SUM_W-1:0]     a_ext;
  logic [pvd_pkg::SUM_W-1:0]     b_ext;
  logic [pvd_pkg::SUM_W-1:0]     diff_ab;
  logic [pvd_pkg::SUM_W-1:0]     mag_a;
  logic [pvd_pkg::SUM_W-1:0]     mag_b;
  logic [pvd_pkg::DIFF_W-1:0]    d_in;
  logic [pvd_pkg::SUM_W-1:0]     s_in;

  logic                          counting;
  logic                          usable;
  logic [3:0]                    after_term;
  logic [pvd_pkg::MUL_W-1:0]     mul_a;
  logic [pvd_pkg::MUL_W-1:0]     mul_b;
  logic [pvd_pkg::ACC_W-1:0]     addend;
  logic [pvd_pkg::ACC_W:0]       acc_sum;
  logic [pvd_pkg::ACC_W-1:0]     acc_sat;
  logic [pvd_pkg::SCALE_W-1:0]   scaled_sum;
  logic [pvd_pkg::ACC_W-1:0]     scale_val;
  logic                          emit_load;
  logic [pvd_pkg::DIST_W-1:0]    emit_distance;
  logic                          emit_missing;
  logic                          emit_saturated;

  pvd_pkg::pvd_req_t             req;
  pvd_pkg::pvd_resp_t            resp;

  pvd_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .resp (resp)
  );

  assign item_stall = (state != ST_IDLE);

  // Pair front end: |a-b| and |a|+|b|.
  always_comb begin
    a_ext   = {value_a[pvd_pkg::VAL_W-1], value_a};
    b_ext   = {value_b[pvd_pkg::VAL_W-1], value_b};
    diff_ab = a_ext - b_ext;
    mag_a   = a_ext[pvd_pkg::SUM_W-1] ? (~a_ext + pvd_pkg::SUM_W'(1)) : a_ext;
    mag_b   = b_ext[pvd_pkg::SUM_W-1] ? (~b_ext + pvd_pkg::SUM_W'(1)) : b_ext;
    if (diff_ab[pvd_pkg::SUM_W-1]) begin
      d_in = pvd_pkg::DIFF_W'(~diff_ab + pvd_pkg::SUM_W'(1));
    end else begin
      d_in = diff_ab[pvd_pkg::DIFF_W-1:0];
    end
    s_in = mag_a + mag_b;
  end

  assign counting   = element_count < pvd_pkg::CNT_W'(pvd_pkg::MAX_COLUMNS);
  assign usable     = counting && !miss_q;
  assign after_term = last_q ? ST_FINAL : ST_IDLE;

  assign scaled_sum = {prod[pvd_pkg::PART_W-1:0], {pvd_pkg::MUL_W{1'b0}}} +
                      pvd_pkg::SCALE_W'(scaled);
  assign scale_val  = resp.overflow ? '1 : resp.value;

  always_comb begin
    unique case (state)
      ST_SCALE_LO: begin
        mul_a = accumulator[pvd_pkg::MUL_W-1:0];
        mul_b = pvd_pkg::MUL_W'(element_count);
      end
      ST_SCALE_HI: begin
        mul_a = accumulator[pvd_pkg::ACC_W-1:pvd_pkg::MUL_W];
        mul_b = pvd_pkg::MUL_W'(element_count);
      end
      default: begin
        mul_a = d_q;
        mul_b = d_q;
      end
    endcase
  end

  always_comb begin
    unique case (state)
      ST_SQ:       addend = pvd_pkg::ACC_W'(prod[pvd_pkg::PROD_W-1:pvd_pkg::FRAC_W]);
      ST_CAN_WAIT: addend = resp.value;
      default:     addend = pvd_pkg::ACC_W'(d_q);
    endcase
    acc_sum = {1'b0, accumulator} + {1'b0, addend};
    acc_sat = acc_sum[pvd_pkg::ACC_W] ? '1 : acc_sum[pvd_pkg::ACC_W-1:0];
  end

  // Launch requests on the shared unit.
  always_comb begin
    req = '0;
    unique case (state)
      ST_TERM: begin
        if (usable && metric == pvd_pkg::METRIC_CANBERRA && s_q != '0) begin
          req.start   = 1'b1;
          req.op      = pvd_pkg::OP_DIV;
          req.steps   = pvd_pkg::CANB_STEPS;
          req.operand = {d_q, {(pvd_pkg::WORK_W - pvd_pkg::DIFF_W){1'b0}}};
          req.divisor = s_q;
        end
      end
      ST_FINAL: begin
        if (metric == pvd_pkg::METRIC_BINARY && used_count != '0 &&
            union_count != '0) begin
          req.start   = 1'b1;
          req.op      = pvd_pkg::OP_DIV;
          req.steps   = pvd_pkg::BIN_STEPS;
          req.operand = {mismatch_count,
                         {(pvd_pkg::WORK_W - pvd_pkg::CNT_W){1'b0}}};
          req.divisor = pvd_pkg::SUM_W'(union_count);
        end
      end
      ST_SCALE_SUM: begin
        req.start   = 1'b1;
        req.op      = pvd_pkg::OP_DIV;
        req.steps   = pvd_pkg::SCALE_STEPS;
        req.operand = {scaled_sum, {(pvd_pkg::WORK_W - pvd_pkg::SCALE_W){1'b0}}};
        req.divisor = pvd_pkg::SUM_W'(used_count);
      end
      ST_SCALE_WAIT: begin
        if (resp.done && metric == pvd_pkg::METRIC_EUCLID) begin
          req.start   = 1'b1;
          req.op      = pvd_pkg::OP_ROOT;
          req.steps   = pvd_pkg::ROOT_STEPS;
          req.operand = {scale_val, {pvd_pkg::FRAC_W{1'b0}}};
        end
      end
      default: begin
      end
    endcase
  end

  assign emit_load = (state == ST_EMIT) && (!result_valid || !result_stall);

  always_comb begin
    if (na_q) begin
      emit_distance  = '0;
      emit_missing   = 1'b1;
      emit_saturated = 1'b0;
    end else if (ov_q || (|val[pvd_pkg::ACC_W-1:pvd_pkg::DIST_W])) begin
      emit_distance  = pvd_pkg::DIST_MAX;
      emit_missing   = 1'b0;
      emit_saturated = 1'b1;
    end else begin
      emit_distance  = val[pvd_pkg::DIST_W-1:0];
      emit_missing   = 1'b0;
      emit_saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      metric             <= pvd_pkg::METRIC_EUCLID;
      accumulator        <= '0;
      element_count      <= '0;
      used_count         <= '0;
      union_count        <= '0;
      mismatch_count     <= '0;
      largest_difference <= '0;
      any_usable         <= 1'b0;
      result_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        metric <= cfg_wr_data;
      end
      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state <= ST_TERM;
          end
        end
        ST_TERM: begin
          if (counting) begin
            element_count <= element_count + pvd_pkg::CNT_W'(1);
          end
          if (usable && metric == pvd_pkg::METRIC_EUCLID) begin
            state <= ST_SQ;
          end else if (usable && metric == pvd_pkg::METRIC_CANBERRA && s_q != '0) begin
            state <= ST_CAN_WAIT;
          end else begin
            state <= after_term;
          end
          if (usable) begin
            any_usable <= 1'b1;
            unique case (metric)
              pvd_pkg::METRIC_MAXIMUM: begin
                if (d_q > largest_difference) begin
                  largest_difference <= d_q;
                end
                used_count <= used_count + pvd_pkg::CNT_W'(1);
              end
              pvd_pkg::METRIC_MANHATT: begin
                accumulator <= acc_sat;
                used_count  <= used_count + pvd_pkg::CNT_W'(1);
              end
              pvd_pkg::METRIC_BINARY: begin
                used_count <= used_count + pvd_pkg::CNT_W'(1);
                if (a_nz || b_nz) begin
                  union_count <= union_count + pvd_pkg::CNT_W'(1);
                  if (!(a_nz && b_nz)) begin
                    mismatch_count <= mismatch_count + pvd_pkg::CNT_W'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SQ: begin
          accumulator <= acc_sat;
          used_count  <= used_count + pvd_pkg::CNT_W'(1);
          state       <= after_term;
        end
        ST_CAN_WAIT: begin
          if (resp.done) begin
            accumulator <= acc_sat;
            used_count  <= used_count + pvd_pkg::CNT_W'(1);
            state       <= after_term;
          end
        end
        ST_FINAL: begin
          unique case (metric)
            pvd_pkg::METRIC_EUCLID,
            pvd_pkg::METRIC_MANHATT,
            pvd_pkg::METRIC_CANBERRA: begin
              state <= (used_count == '0) ? ST_EMIT : ST_SCALE_LO;
            end
            pvd_pkg::METRIC_BINARY: begin
              if (used_count != '0 && union_count != '0) begin
                state <= ST_BIN_WAIT;
              end else begin
                state <= ST_EMIT;
              end
            end
            default: begin
              state <= ST_EMIT;
            end
          endcase
        end
        ST_SCALE_LO: begin
          state <= ST_SCALE_HI;
        end
        ST_SCALE_HI: begin
          state <= ST_SCALE_SUM;
        end
        ST_SCALE_SUM: begin
          state <= ST_SCALE_WAIT;
        end
        ST_SCALE_WAIT: begin
          if (resp.done) begin
            state <= (metric == pvd_pkg::METRIC_EUCLID) ? ST_ROOT_WAIT : ST_EMIT;
          end
        end
        ST_ROOT_WAIT, ST_BIN_WAIT: begin
          if (resp.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            accumulator        <= '0;
            element_count      <= '0;
            used_count         <= '0;
            union_count        <= '0;
            mismatch_count     <= '0;
            largest_difference <= '0;
            any_usable         <= 1'b0;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= pvd_pkg::PROD_W'(mul_a) * pvd_pkg::PROD_W'(mul_b);
    if (state == ST_IDLE && item_valid) begin
      d_q    <= d_in;
      s_q    <= s_in;
      a_nz   <= (value_a != '0);
      b_nz   <= (value_b != '0);
      miss_q <= missing_a || missing_b;
      last_q <= last_element;
    end
    if (state == ST_SCALE_HI) begin
      scaled <= prod[pvd_pkg::PART_W-1:0];
    end
    if (state == ST_FINAL) begin
      ov_q <= (accumulator == '1);
      unique case (metric)
        pvd_pkg::METRIC_EUCLID,
        pvd_pkg::METRIC_MANHATT,
        pvd_pkg::METRIC_CANBERRA,
        pvd_pkg::METRIC_BINARY: begin
          na_q <= (used_count == '0);
          val  <= '0;
        end
        pvd_pkg::METRIC_MAXIMUM: begin
          na_q <= !any_usable;
          val  <= pvd_pkg::ACC_W'(largest_difference);
        end
        default: begin
          na_q <= 1'b1;
          val  <= '0;
        end
      endcase
    end
    if (state == ST_SCALE_WAIT && resp.done) begin
      val  <= scale_val;
      ov_q <= ov_q || resp.overflow;
    end
    if ((state == ST_ROOT_WAIT || state == ST_BIN_WAIT) && resp.done) begin
      val <= resp.value;
    end
    if (emit_load) begin
      distance       <= emit_distance;
      result_missing <= emit_missing;
      saturated      <= emit_saturated;
    end
  end

  `ASSERT_IMPLY(a_used_le_elements, clk, rst, 1'b1, used_count <= element_count)
  `ASSERT_IMPLY(a_binary_counts, clk, rst, 1'b1, mismatch_count <= union_count && union_count <= used_count)
  `ASSERT_IMPLY(a_na_result_clean, clk, rst, result_valid && result_missing, distance == '0 && !saturated)
  `ASSERT_NEXT(a_accept_holds_off, clk, rst, item_valid && !item_stall, item_stall)

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives coordinate pairs into pairwise_vector_distance_core under every
// metric code, predicts each distance result in step with every accepted
// pair transfer, and compares the results field by field as they leave the
// core. The pair input idles and the result output stalls at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int          RANDOM_ITEMS  = 300;
  localparam int          SETTLE_CYCLES = 300;
  localparam int          CYCLE_LIMIT   = 2_000_000;
  localparam logic [31:0] COORD_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] COORD_MIN     = 32'h8000_0000;

  typedef struct packed {
    logic [pvd_pkg::DIST_W-1:0] dist_value;
    logic                       na;
    logic                       sat;
  } result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [2:0]        cfg_wr_data;
  logic              item_valid;
  logic              item_stall;
  logic signed [pvd_pkg::VAL_W-1:0] value_a;
  logic signed [pvd_pkg::VAL_W-1:0] value_b;
  logic              missing_a;
  logic              missing_b;
  logic              last_element;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [pvd_pkg::DIST_W-1:0] distance;
  logic              result_missing;
  logic              saturated;

  // predicted vector state
  logic [2:0]        cur_metric;
  logic [63:0]       sum_acc;
  logic [63:0]       widest;
  int unsigned       n_seen;
  int unsigned       n_used;
  int unsigned       n_union;
  int unsigned       n_mismatch;
  bit                any_usable;

  result_t           pending_distances[$];
  int                error_count = 0;
  int                cycle_count = 0;
  int                rx_hold = 0;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;

  pairwise_vector_distance_core u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .value_a        (value_a),
    .value_b        (value_b),
    .missing_a      (missing_a),
    .missing_b      (missing_b),
    .last_element   (last_element),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .distance       (distance),
    .result_missing (result_missing),
    .saturated      (saturated)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pairwise_vector_distance_core: mismatch");
      $finish;
    end
  end

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_MAX;
      2: return COORD_MIN;
      3: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_metric();
    int r;
    r = $urandom_range(0, 17);
    if (r < 15) return 3'(r % 5);
    return 3'(r - 10);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 200);
  endfunction

  function automatic logic [63:0] magnitude(input logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // {overflow, floor(sum * n / u)}; sum as it is when u is 0 or u >= n
  function automatic logic [64:0] rescale_sum(input logic [63:0] sum, input int unsigned n,
                                               input int unsigned u);
    logic [127:0] wide;
    if (u == 0 || u >= n) return {1'b0, sum};
    wide = (128'(sum) * 128'(n)) / 128'(u);
    if (wide[127:64] != 0) return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
    return {1'b0, wide[63:0]};
  endfunction

  // floor(sqrt(y * 2^16))
  function automatic logic [63:0] root_q16(input logic [63:0] y);
    logic [79:0] x;
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] trial;
    x = {y, 16'd0};
    rem = '0;
    root = '0;
    for (int k = 39; k >= 0; k--) begin
      rem = (rem << 2) | 64'(x[2*k +: 2]);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  task automatic clear_vector();
    sum_acc = '0;
    widest = '0;
    n_seen = 0;
    n_used = 0;
    n_union = 0;
    n_mismatch = 0;
    any_usable = 1'b0;
  endtask

  task automatic add_to_sum(input logic [63:0] term);
    sum_acc = (sum_acc > ~term) ? '1 : sum_acc + term;
  endtask

  function automatic result_t finish_vector();
    result_t     r;
    logic [64:0] scaled;
    logic [63:0] v;
    bit          na;
    bit          ov;
    v = '0;
    na = 1'b0;
    ov = (sum_acc == '1);
    case (cur_metric)
      pvd_pkg::METRIC_EUCLID: begin
        if (n_used == 0) begin
          na = 1'b1;
        end else begin
          scaled = rescale_sum(sum_acc, n_seen, n_used);
          ov |= scaled[64];
          v = root_q16(scaled[63:0]);
        end
      end
      pvd_pkg::METRIC_MAXIMUM: begin
        if (!any_usable) na = 1'b1;
        else v = widest;
      end
      pvd_pkg::METRIC_MANHATT, pvd_pkg::METRIC_CANBERRA: begin
        if (n_used == 0) begin
          na = 1'b1;
        end else begin
          scaled = rescale_sum(sum_acc, n_seen, n_used);
          ov |= scaled[64];
          v = scaled[63:0];
        end
      end
      pvd_pkg::METRIC_BINARY: begin
        if (n_used == 0) na = 1'b1;
        else if (n_union != 0) v = (64'(n_mismatch) << 16) / 64'(n_union);
      end
      default: na = 1'b1;
    endcase
    r.na = na;
    if (na) begin
      r.dist_value = '0;
      r.sat = 1'b0;
    end else if (ov || v > 64'(pvd_pkg::DIST_MAX)) begin
      r.dist_value = pvd_pkg::DIST_MAX;
      r.sat = 1'b1;
    end else begin
      r.dist_value = v[pvd_pkg::DIST_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  task automatic fold_pair(input logic signed [31:0] a, b, input bit ma, mb, last);
    logic [63:0] d;
    logic [63:0] s;
    d = magnitude(64'(a) - 64'(b));
    s = magnitude(64'(a)) + magnitude(64'(b));
    if (n_seen < pvd_pkg::MAX_COLUMNS) begin
      n_seen++;
      if (!(ma || mb)) begin
        any_usable = 1'b1;
        case (cur_metric)
          pvd_pkg::METRIC_EUCLID: begin
            add_to_sum((d * d) >> 16);
            n_used++;
          end
          pvd_pkg::METRIC_MAXIMUM: begin
            if (d > widest) widest = d;
            n_used++;
          end
          pvd_pkg::METRIC_MANHATT: begin
            add_to_sum(d);
            n_used++;
          end
          pvd_pkg::METRIC_CANBERRA: begin
            if (s != 0) begin
              add_to_sum((d << 16) / s);
              n_used++;
            end
          end
          pvd_pkg::METRIC_BINARY: begin
            n_used++;
            if (a != 0 || b != 0) begin
              n_union++;
              if (a == 0 || b == 0) n_mismatch++;
            end
          end
          default: ;
        endcase
      end
    end
    if (last) begin
      pending_distances.push_back(finish_vector());
      clear_vector();
    end
  endtask

  task automatic report_mismatch(input string why, input result_t want);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: expected distance %h missing %b saturated %b, got %h %b %b",
               $time, why, want.dist_value, want.na, want.sat, distance, result_missing,
               saturated);
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) rx_hold = rx_hold - 1;
    else if (!rx_steady) rx_hold = next_gap();
    result_stall <= (rx_hold != 0);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_distances.size() == 0) begin
        report_mismatch("unexpected result", '0);
      end else begin
        want = pending_distances.pop_front();
        if (distance !== want.dist_value || result_missing !== want.na ||
            saturated !== want.sat)
          report_mismatch("wrong result", want);
      end
    end
  end

  task automatic send_pair(input logic signed [31:0] a, b, input bit ma, mb, last);
    int gap;
    gap = tx_steady ? 0 : next_gap();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value_a <= a;
    value_b <= b;
    missing_a <= ma;
    missing_b <= mb;
    last_element <= last;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    fold_pair(a, b, ma, mb, last);
  endtask

  // hold off until every result is in and the core has settled
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_metric(input logic [2:0] m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_metric = m;
  endtask

  task automatic test_each_metric();
    for (int m = pvd_pkg::METRIC_EUCLID; m <= pvd_pkg::METRIC_BINARY; m++) begin
      if (m != pvd_pkg::METRIC_EUCLID) set_metric(3'(m));
      send_pair(COORD_MAX, COORD_MIN, 1'b0, 1'b0, 1'b0);
      send_pair('0, '0, 1'b0, 1'b0, 1'b0);
      send_pair(COORD_MIN, COORD_MAX, 1'b1, 1'b1, 1'b0);
      send_pair('0, COORD_MIN, 1'b0, 1'b0, 1'b1);
      wait_idle();
    end
  endtask

  task automatic test_nothing_usable();
    set_metric(pvd_pkg::METRIC_MAXIMUM);
    send_pair(COORD_MAX, '0, 1'b0, 1'b1, 1'b1);
    wait_idle();
    set_metric(pvd_pkg::METRIC_CANBERRA);
    send_pair('0, '0, 1'b0, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_binary_all_zero();
    set_metric(pvd_pkg::METRIC_BINARY);
    send_pair('0, '0, 1'b0, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_unknown_metric();
    for (int m = int'(pvd_pkg::METRIC_BINARY) + 1; m < (1 << $bits(cfg_wr_data)); m++) begin
      set_metric(3'(m));
      send_pair(rand_coord(), rand_coord(), 1'b0, 1'b0, 1'b1);
      wait_idle();
    end
  endtask

  task automatic test_metric_switch();
    set_metric(pvd_pkg::METRIC_EUCLID);
    send_pair(COORD_MAX, '0, 1'b0, 1'b0, 1'b0);
    wait_idle();
    set_metric(pvd_pkg::METRIC_MANHATT);
    send_pair(COORD_MIN, '0, 1'b0, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_vectors();
    int sent;
    int len;
    int vectors;
    sent = 0;
    vectors = 0;
    while (sent < RANDOM_ITEMS) begin
      if (vectors % 3 == 0) begin
        wait_idle();
        set_metric(pick_metric());
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      len = pick_length();
      for (int i = 1; i <= len; i++)
        send_pair(rand_coord(), rand_coord(), $urandom_range(0, 9) == 0,
                  $urandom_range(0, 9) == 0, i == len);
      sent += len;
      vectors++;
    end
    wait_idle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_overlong_vector();
    int len;
    len = pvd_pkg::MAX_COLUMNS + 3;
    set_metric(pvd_pkg::METRIC_MANHATT);
    tx_steady = 1'b1;
    for (int i = 1; i <= len; i++)
      send_pair(rand_coord(), rand_coord(), $urandom_range(0, 9) == 0, 1'b0, i == len);
    wait_idle();
    tx_steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    item_valid = 1'b0;
    value_a = '0;
    value_b = '0;
    missing_a = 1'b0;
    missing_b = 1'b0;
    last_element = 1'b0;
    cur_metric = pvd_pkg::METRIC_EUCLID;
    clear_vector();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_each_metric();
    test_nothing_usable();
    test_binary_all_zero();
    test_unknown_metric();
    test_metric_switch();
    test_random_vectors();
    test_overlong_vector();
    if (error_count == 0 && pending_distances.size() == 0)
      $display("pairwise_vector_distance_core: match");
    else
      $display("pairwise_vector_distance_core: mismatch");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/pvd_pkg.sv
hw/rtl/pvd_divsqrt.sv
hw/rtl/pairwise_vector_distance_core.sv
test/testbench.sv
